// ===== hw/rtl/rba_pkg.sv =====
`default_nettype none
package rba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam logic [12:0] PAGE_BYTES   = 13'd4096;
  localparam logic [2:0]  FAIL_LIMIT   = 3'd4;
  localparam logic [2:0]  FAIL_SAT     = 3'd7;
  localparam logic [9:0]  HEADER_ALIGN = 10'd16;
  localparam logic [11:0] SIZE_CAP     = 12'd4095;
  localparam logic [12:0] BS_RESET     = 13'd4096;
  localparam logic [8:0]  HDR_RESET    = 9'd32;

  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_HEADER     = 1'b1;

  typedef enum logic [2:0] {
    ST_EXIST = 3'd0,
    ST_NEW   = 3'd1,
    ST_ZERO  = 3'd2,
    ST_BIG   = 3'd3,
    ST_FULL  = 3'd4,
    ST_CLEAR = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_ZERO,
    K_BIG,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] size;
    logic [12:0] align;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  blk;
    logic [11:0] off;
  } res_t;

  typedef struct packed {
    logic [12:0] bsize;
    logic [8:0]  hdr;
  } cfg_t;

  // (x + a - 1) with the bits of (a - 1) cleared; a is never zero here
  function automatic logic [13:0] round_up(input logic [12:0] x, input logic [12:0] a);
    logic [13:0] s;
    logic [13:0] m;
    s = {1'b0, x} + {1'b0, a} - 14'd1;
    m = {1'b0, a - 13'd1};
    return s & ~m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rba_ram.sv =====
`default_nettype none
module rba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rba_fifo.sv =====
`default_nettype none
module rba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rba_front.sv =====
`default_nettype none
module rba_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [12:0]   cfg_data,
  input  wire logic          action,
  input  wire logic [15:0]   alloc_size,
  input  wire logic [12:0]   alignment,
  output rba_pkg::cmd_t      cmd,
  output rba_pkg::cfg_t      cfg
);
  logic [12:0] block_size;
  logic [8:0]  header_bytes;
  logic [12:0] bsize;
  logic [9:0]  hdr16;
  logic [12:0] room;
  logic [11:0] max_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= rba_pkg::BS_RESET;
      header_bytes <= rba_pkg::HDR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rba_pkg::REG_BLOCK_SIZE: block_size   <= cfg_data;
        rba_pkg::REG_HEADER:     header_bytes <= cfg_data[8:0];
        default:                 block_size   <= block_size;
      endcase
    end
  end

  always_comb begin
    bsize    = (block_size > rba_pkg::PAGE_BYTES) ? rba_pkg::PAGE_BYTES : block_size;
    hdr16    = ({1'b0, header_bytes} + (rba_pkg::HEADER_ALIGN - 10'd1))
               & ~(rba_pkg::HEADER_ALIGN - 10'd1);
    room     = ({3'b0, hdr16} >= bsize) ? 13'd0 : bsize - {3'b0, hdr16};
    max_size = (room > {1'b0, rba_pkg::SIZE_CAP}) ? rba_pkg::SIZE_CAP : room[11:0];

    cfg.bsize = bsize;
    cfg.hdr   = header_bytes;

    cmd.size  = alloc_size[11:0];
    cmd.align = (alignment == 13'd0) ? 13'd1 : alignment;
    if (action) begin
      cmd.kind = rba_pkg::K_CLEAR;
    end else if (alloc_size == 16'd0) begin
      cmd.kind = rba_pkg::K_ZERO;
    end else if (alloc_size > {4'b0, max_size}) begin
      cmd.kind = rba_pkg::K_BIG;
    end else begin
      cmd.kind = rba_pkg::K_ALLOC;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rba_back.sv =====
`default_nettype none
module rba_back #(
  parameter int MAX_BLOCKS = rba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  rba_pkg::cfg_t cfg,
  input  rba_pkg::cmd_t cmd,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  output rba_pkg::res_t res,
  output logic          res_push,
  input  wire logic     res_full
);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHECK, S_NEW, S_FREAD, S_FCHECK, S_OPEN, S_DONE
  } state_t;

  state_t        state;
  logic [CNT_W-1:0] b;
  logic [CNT_W-1:0] in_use;
  logic [IDX_W-1:0] cur;
  rba_pkg::cmd_t cmd_q;
  logic [12:0]   pos_q;
  rba_pkg::res_t res_q;

  logic          ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [15:0]   ram_rdata;

  logic [13:0]   pos_scan;
  logic          fits_scan;
  logic [13:0]   pos_new;
  logic          fits_new;
  logic [2:0]    fail_inc;

  rba_ram #(.WIDTH(16), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (b[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // word layout: free pointer in [15:3], failure count in [2:0]
  always_comb begin
    pos_scan  = rba_pkg::round_up(ram_rdata[15:3], cmd_q.align);
    fits_scan = ({1'b0, pos_scan} + {3'b0, cmd_q.size}) <= {2'b0, cfg.bsize};
    pos_new   = rba_pkg::round_up({4'b0, cfg.hdr}, cmd_q.align);
    fits_new  = ({1'b0, pos_new} + {3'b0, cmd_q.size}) <= {2'b0, cfg.bsize};
    fail_inc  = (ram_rdata[2:0] < rba_pkg::FAIL_SAT) ? ram_rdata[2:0] + 3'd1
                                                    : ram_rdata[2:0];

    ram_re    = (state == S_SCAN && b < in_use) || state == S_FREAD;
    ram_we    = 1'b0;
    ram_waddr = b[IDX_W-1:0];
    ram_wdata = {ram_rdata[15:3], fail_inc};
    case (state)
      S_CHECK: begin
        ram_we    = fits_scan;
        ram_wdata = {pos_scan[12:0] + {1'b0, cmd_q.size}, ram_rdata[2:0]};
      end
      S_FCHECK: begin
        ram_we = 1'b1;
      end
      S_OPEN: begin
        ram_we    = 1'b1;
        ram_waddr = in_use[IDX_W-1:0];
        ram_wdata = {pos_q + {1'b0, cmd_q.size}, 3'd0};
      end
      default: ram_we = 1'b0;
    endcase

    cmd_pop  = (state == S_IDLE) && !cmd_empty && !res_full;
    res_push = (state == S_DONE);
    res      = res_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
      cur    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_q <= cmd;
            case (cmd.kind)
              rba_pkg::K_CLEAR: begin
                in_use <= '0;
                cur    <= '0;
                res_q  <= '{rba_pkg::ST_CLEAR, 6'd0, 12'd0};
                state  <= S_DONE;
              end
              rba_pkg::K_ZERO: begin
                res_q <= '{rba_pkg::ST_ZERO, 6'd0, 12'd0};
                state <= S_DONE;
              end
              rba_pkg::K_BIG: begin
                res_q <= '{rba_pkg::ST_BIG, 6'd0, 12'd0};
                state <= S_DONE;
              end
              default: begin
                b     <= CNT_W'(cur);
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          state <= (b < in_use) ? S_CHECK : S_NEW;
        end
        S_CHECK: begin
          if (fits_scan) begin
            res_q <= '{rba_pkg::ST_EXIST, 6'(b), pos_scan[11:0]};
            state <= S_DONE;
          end else begin
            b     <= b + 1'b1;
            state <= S_SCAN;
          end
        end
        S_NEW: begin
          if (in_use >= CNT_W'(MAX_BLOCKS)) begin
            res_q <= '{rba_pkg::ST_FULL, 6'd0, 12'd0};
            state <= S_DONE;
          end else if (!fits_new) begin
            res_q <= '{rba_pkg::ST_BIG, 6'd0, 12'd0};
            state <= S_DONE;
          end else begin
            pos_q <= pos_new[12:0];
            b     <= CNT_W'(cur);
            if (in_use == '0) begin
              cur <= '0;
            end
            // older blocks from the current one, newest excluded, count a failure
            state <= (({1'b0, CNT_W'(cur)} + 1'b1) < {1'b0, in_use}) ? S_FREAD : S_OPEN;
          end
        end
        S_FREAD: begin
          state <= S_FCHECK;
        end
        S_FCHECK: begin
          if (ram_rdata[2:0] > rba_pkg::FAIL_LIMIT) begin
            cur <= IDX_W'(b + 1'b1);
          end
          b     <= b + 1'b1;
          state <= (({1'b0, b} + 2'd2) < {1'b0, in_use}) ? S_FREAD : S_OPEN;
        end
        S_OPEN: begin
          in_use <= in_use + 1'b1;
          res_q  <= '{rba_pkg::ST_NEW, 6'(in_use), pos_q[11:0]};
          state  <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= CNT_W'(MAX_BLOCKS))
    else $error("blocks in use beyond pool");

  a_cur_below_use: assert property (@(posedge clk) disable iff (rst)
    in_use != '0 |-> CNT_W'(cur) < in_use)
    else $error("current block beyond opened blocks");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state != S_IDLE)
    else $error("request taken but not started");

endmodule
`default_nettype wire

// ===== hw/rtl/region_block_allocator.sv =====
// Clear, zero-size and too-large requests pass only the back-end IDLE and DONE states.
// An allocate walks from the current block, a SCAN and a CHECK state per block read;
// opening a new block adds an FREAD and an FCHECK state per older block passed.
// The back-end sequencer takes one request at a time, bounded by the RAM walk.
// Reset (rst, synchronous): pool empty, current block 0, queues empty,
// block_size 4096 and header_bytes 32.
`default_nettype none
module region_block_allocator #(
  parameter int MAX_BLOCKS = rba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [15:0] alloc_size,
  input  wire logic [12:0] alignment,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status,
  output logic [5:0]       block_index,
  output logic [11:0]      byte_offset,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  localparam int CMD_W = $bits(rba_pkg::cmd_t);
  localparam int RES_W = $bits(rba_pkg::res_t);

  rba_pkg::cmd_t cmd_in;
  rba_pkg::cmd_t cmd_out;
  rba_pkg::cfg_t cfg;
  rba_pkg::res_t res_in;
  rba_pkg::res_t res_out;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;

  rba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .alloc_size (alloc_size),
    .alignment  (alignment),
    .cmd        (cmd_in),
    .cfg        (cfg)
  );

  rba_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  rba_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign status      = res_out.status;
  assign block_index = res_out.blk;
  assign byte_offset = res_out.off;

endmodule
`default_nettype wire
